@@ rtl/mmsos_pkg.sv @@
// Shared constants, step/status types and the digit inverse helper for the
// SOS Montgomery multiplier. No dependencies; compiled first.
package mmsos_pkg;

  localparam int unsigned DIGIT_BITS = 4;
  localparam int unsigned FIELD_W    = 64;
  localparam int unsigned DC_W       = 5;
  localparam int unsigned DIGITS_DEF = 16;
  localparam int unsigned PADDR_W    = 4;

  localparam logic [FIELD_W-1:0] MODULUS_RST = 64'd255;
  localparam logic [DC_W-1:0]    DC_RST      = 5'd2;

  // register index = paddr[3]
  localparam logic REG_MODULUS     = 1'b0;
  localparam logic REG_DIGIT_COUNT = 1'b1;

  // datapath step kinds
  localparam logic [1:0] K_MAC   = 2'd0;  // t[p] += mul*opd + carry
  localparam logic [1:0] K_LEAD  = 2'd1;  // m = t[i]*n0' mod 16
  localparam logic [1:0] K_FIN   = 2'd2;  // U - n digit with borrow
  localparam logic [1:0] K_SHIFT = 2'd3;  // align result digits

  typedef struct packed {
    logic                  vld;
    logic [1:0]            kind;
    logic                  zero_rd;  // read data counts as zero
    logic                  first;    // clear carry / borrow in
    logic                  keep;     // final digit goes into result
    logic                  use_m;    // multiplier digit is m
    logic [DIGIT_BITS-1:0] opd;
    logic [DIGIT_BITS-1:0] mul;
  } step_t;

  typedef struct packed {
    logic idle;
    logic done;
    logic bad;
  } seq_stat_t;

  // x with n0*x == -1 mod 16, smallest such x; 0 for even n0
  function automatic logic [DIGIT_BITS-1:0] neg_inv(input logic [DIGIT_BITS-1:0] n0);
    logic [DIGIT_BITS-1:0]   r;
    logic [2*DIGIT_BITS-1:0] pr;
    r  = '0;
    pr = '0;
    for (int x = (1 << DIGIT_BITS) - 1; x >= 0; x--) begin
      pr = {{DIGIT_BITS{1'b0}}, n0} * (2*DIGIT_BITS)'(x);
      if (pr[DIGIT_BITS-1:0] == {DIGIT_BITS{1'b1}}) begin
        r = DIGIT_BITS'(x);
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/mmsos_if.sv @@
// Valid/ready channel interfaces for operand items and result items.
// Depends on mmsos_pkg.
interface mmsos_in_if;
  logic                             valid;
  logic                             ready;
  logic [mmsos_pkg::FIELD_W-1:0]    operand_a;
  logic [mmsos_pkg::FIELD_W-1:0]    operand_b;

  modport source (output valid, output operand_a, output operand_b, input ready);
  modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

interface mmsos_out_if;
  logic                             valid;
  logic                             ready;
  logic [mmsos_pkg::FIELD_W-1:0]    product;
  logic                             bad_modulus;

  modport source (output valid, output product, output bad_modulus, input ready);
  modport sink   (input valid, input product, input bad_modulus, output ready);
endinterface

@@ rtl/mmsos_cfg.sv @@
// APB-style register file: modulus and digit_count.
// Depends on mmsos_pkg.
module mmsos_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mmsos_pkg::PADDR_W-1:0]     paddr,
  input  logic [mmsos_pkg::FIELD_W-1:0]     pwdata,
  output logic [mmsos_pkg::FIELD_W-1:0]     prdata,
  output logic                              pready,
  output logic [mmsos_pkg::FIELD_W-1:0]     modulus,
  output logic [mmsos_pkg::DC_W-1:0]        digit_count
);
  import mmsos_pkg::*;

  logic [FIELD_W-1:0] modulus_r, modulus_nxt;
  logic [DC_W-1:0]    dc_r, dc_nxt;
  logic               wr_en;
  logic               reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3];

  always_comb begin
    modulus_nxt = modulus_r;
    dc_nxt      = dc_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_MODULUS:     modulus_nxt = pwdata;
        REG_DIGIT_COUNT: dc_nxt      = pwdata[DC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MODULUS:     prdata = modulus_r;
      REG_DIGIT_COUNT: prdata = FIELD_W'(dc_r);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MODULUS_RST;
      dc_r      <= DC_RST;
    end else begin
      modulus_r <= modulus_nxt;
      dc_r      <= dc_nxt;
    end
  end

  assign modulus     = modulus_r;
  assign digit_count = dc_r;

endmodule

@@ rtl/mmsos_seq.sv @@
// Step sequencer: operand shift registers and pass/position counters that
// issue one digit step per cycle to the datapath. Depends on mmsos_pkg.
module mmsos_seq #(
  parameter int unsigned DIGITS = mmsos_pkg::DIGITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              take,
  input  logic [mmsos_pkg::FIELD_W-1:0]     operand_a,
  input  logic [mmsos_pkg::FIELD_W-1:0]     operand_b,
  input  logic [mmsos_pkg::FIELD_W-1:0]     modulus,
  input  logic [mmsos_pkg::DC_W-1:0]        digit_count,
  output mmsos_pkg::step_t                  step,
  output logic [$clog2(2*DIGITS+1)-1:0]     addr,
  output mmsos_pkg::seq_stat_t              stat
);
  import mmsos_pkg::*;

  localparam int unsigned DW = DIGITS * DIGIT_BITS;
  localparam int unsigned SW = $clog2(DIGITS + 1);
  localparam int unsigned AW = $clog2(2*DIGITS + 1);
  localparam int unsigned IW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PROD  = 3'd1;
  localparam logic [2:0] S_LEAD  = 3'd2;
  localparam logic [2:0] S_RED   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;
  localparam logic [2:0] S_ALIGN = 3'd5;
  localparam logic [2:0] S_WAIT  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]            state_r, state_nxt;
  logic [SW-1:0]         s_r, s_nxt, k_r, k_nxt;
  logic [IW-1:0]         i_r, i_nxt;
  logic [AW-1:0]         j_r, j_nxt, p_r, p_nxt;
  logic [DW-1:0]         a_r, a_nxt, a_sr_r, a_sr_nxt, b_sr_r, b_sr_nxt;
  logic [DW-1:0]         n_r, n_nxt, n_sr_r, n_sr_nxt;
  logic [DIGIT_BITS-1:0] ninv_r, ninv_nxt;
  logic                  bad_r, bad_nxt;

  logic [SW-1:0]         s_eff;
  logic [DW-1:0]         dmask;
  logic [AW-1:0]         s_ext, two_s, end_j;
  logic                  last_pass;

  assign s_ext     = AW'(s_r);
  assign two_s     = AW'({s_r, 1'b0});
  assign last_pass = (AW'(i_r) == s_ext - AW'(1));
  assign end_j     = last_pass ? s_ext + AW'(1) : s_ext;

  // effective digit count and digit mask for a new item
  always_comb begin
    if (digit_count == '0) begin
      s_eff = SW'(1);
    end else if (digit_count > DC_W'(DIGITS)) begin
      s_eff = SW'(DIGITS);
    end else begin
      s_eff = SW'(digit_count);
    end
    for (int k = 0; k < int'(DIGITS); k++) begin
      dmask[k*DIGIT_BITS +: DIGIT_BITS] = (k < int'(s_eff)) ? '1 : '0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    s_nxt     = s_r;
    k_nxt     = k_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    p_nxt     = p_r;
    a_nxt     = a_r;
    a_sr_nxt  = a_sr_r;
    b_sr_nxt  = b_sr_r;
    n_nxt     = n_r;
    n_sr_nxt  = n_sr_r;
    ninv_nxt  = ninv_r;
    bad_nxt   = bad_r;
    step      = '0;
    addr      = p_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          s_nxt    = s_eff;
          a_nxt    = operand_a[DW-1:0] & dmask;
          a_sr_nxt = operand_a[DW-1:0] & dmask;
          b_sr_nxt = operand_b[DW-1:0] & dmask;
          n_nxt    = modulus[DW-1:0] & dmask;
          n_sr_nxt = modulus[DW-1:0] & dmask;
          ninv_nxt = neg_inv(modulus[DIGIT_BITS-1:0]);
          bad_nxt  = !modulus[0];
          i_nxt    = '0;
          j_nxt    = '0;
          p_nxt    = '0;
          state_nxt = modulus[0] ? S_PROD : S_DONE;
        end
      end

      // product pass i: t[i+j] += a[j]*b[i]; first pass sees an empty t
      S_PROD: begin
        step.vld     = 1'b1;
        step.kind    = K_MAC;
        step.zero_rd = (i_r == '0) || (j_r >= s_ext);
        step.first   = (j_r == '0);
        step.opd     = a_sr_r[DIGIT_BITS-1:0];
        step.mul     = b_sr_r[DIGIT_BITS-1:0];
        a_sr_nxt     = a_sr_r >> DIGIT_BITS;
        j_nxt        = j_r + AW'(1);
        p_nxt        = p_r + AW'(1);
        if (j_r == end_j) begin
          j_nxt = '0;
          if (last_pass) begin
            i_nxt     = '0;
            p_nxt     = '0;
            n_sr_nxt  = n_r;
            state_nxt = S_LEAD;
          end else begin
            i_nxt    = i_r + IW'(1);
            p_nxt    = AW'(i_r) + AW'(1);
            a_sr_nxt = a_r;
            b_sr_nxt = b_sr_r >> DIGIT_BITS;
          end
        end
      end

      S_LEAD: begin
        step.vld  = 1'b1;
        step.kind = K_LEAD;
        step.mul  = ninv_r;
        j_nxt     = '0;
        state_nxt = S_RED;
      end

      // reduction pass i: add m*n at digit i, carry ripples to the top
      S_RED: begin
        step.vld   = 1'b1;
        step.kind  = K_MAC;
        step.first = (j_r == '0);
        step.use_m = 1'b1;
        step.opd   = n_sr_r[DIGIT_BITS-1:0];
        n_sr_nxt   = n_sr_r >> DIGIT_BITS;
        j_nxt      = j_r + AW'(1);
        p_nxt      = p_r + AW'(1);
        if (p_r == two_s) begin
          n_sr_nxt = n_r;
          j_nxt    = '0;
          if (last_pass) begin
            p_nxt     = s_ext;
            state_nxt = S_FIN;
          end else begin
            i_nxt     = i_r + IW'(1);
            p_nxt     = AW'(i_r) + AW'(1);
            state_nxt = S_LEAD;
          end
        end
      end

      // U - n over digits s..2s
      S_FIN: begin
        step.vld   = 1'b1;
        step.kind  = K_FIN;
        step.first = (j_r == '0);
        step.keep  = (p_r != two_s);
        step.opd   = n_sr_r[DIGIT_BITS-1:0];
        n_sr_nxt   = n_sr_r >> DIGIT_BITS;
        j_nxt      = j_r + AW'(1);
        p_nxt      = p_r + AW'(1);
        if (p_r == two_s) begin
          if (s_r == SW'(DIGITS)) begin
            state_nxt = S_WAIT;
          end else begin
            k_nxt     = SW'(DIGITS) - s_r;
            state_nxt = S_ALIGN;
          end
        end
      end

      S_ALIGN: begin
        step.vld  = 1'b1;
        step.kind = K_SHIFT;
        k_nxt     = k_r - SW'(1);
        if (k_r == SW'(1)) begin
          state_nxt = S_WAIT;
        end
      end

      S_WAIT: state_nxt = S_DONE;

      S_DONE: begin
        if (take) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bad_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      bad_r   <= bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r    <= s_nxt;
    k_r    <= k_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    p_r    <= p_nxt;
    a_r    <= a_nxt;
    a_sr_r <= a_sr_nxt;
    b_sr_r <= b_sr_nxt;
    n_r    <= n_nxt;
    n_sr_r <= n_sr_nxt;
    ninv_r <= ninv_nxt;
  end

  assign stat.idle = (state_r == S_IDLE);
  assign stat.done = (state_r == S_DONE);
  assign stat.bad  = bad_r;

endmodule

@@ rtl/mmsos_dpath.sv @@
// Digit datapath: t digit memory, 4x4 multiply-accumulate, borrow chain and
// result shift registers. Depends on mmsos_pkg.
module mmsos_dpath #(
  parameter int unsigned DIGITS = mmsos_pkg::DIGITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  mmsos_pkg::step_t                       step,
  input  logic [$clog2(2*DIGITS+1)-1:0]          addr,
  output logic [DIGITS*mmsos_pkg::DIGIT_BITS-1:0] result
);
  import mmsos_pkg::*;

  localparam int unsigned DW = DIGITS * DIGIT_BITS;
  localparam int unsigned AW = $clog2(2*DIGITS + 1);
  localparam int unsigned TD = 2*DIGITS + 1;

  logic [DIGIT_BITS-1:0]   t_mem_r [TD];
  logic [DIGIT_BITS-1:0]   rd_r;
  step_t                   stp_r;
  logic [AW-1:0]           addr_r;
  logic [DIGIT_BITS-1:0]   carry_r, carry_nxt, m_r, m_nxt;
  logic                    borrow_r, borrow_nxt;
  logic [DW-1:0]           u_sr_r, u_sr_nxt, d_sr_r, d_sr_nxt;

  logic [DIGIT_BITS-1:0]   rd_eff, opd_sel, mul_d, cin;
  logic [2*DIGIT_BITS-1:0] prod, sum;
  logic [DIGIT_BITS:0]     sub, diff;
  logic                    mem_we;

  assign rd_eff  = stp_r.zero_rd ? '0 : rd_r;
  assign opd_sel = (stp_r.kind == K_LEAD) ? rd_r : stp_r.opd;
  assign mul_d   = stp_r.use_m ? m_r : stp_r.mul;
  assign cin     = stp_r.first ? '0 : carry_r;
  assign prod    = {{DIGIT_BITS{1'b0}}, mul_d} * {{DIGIT_BITS{1'b0}}, opd_sel};
  assign sum     = {{DIGIT_BITS{1'b0}}, rd_eff} + prod + {{DIGIT_BITS{1'b0}}, cin};
  assign sub     = {1'b0, stp_r.opd} + {{DIGIT_BITS{1'b0}}, (!stp_r.first && borrow_r)};
  assign diff    = {1'b0, rd_r} - sub;
  assign mem_we  = stp_r.vld && (stp_r.kind == K_MAC);

  always_comb begin
    carry_nxt  = carry_r;
    m_nxt      = m_r;
    borrow_nxt = borrow_r;
    u_sr_nxt   = u_sr_r;
    d_sr_nxt   = d_sr_r;
    if (stp_r.vld) begin
      case (stp_r.kind)
        K_MAC:  carry_nxt = sum[2*DIGIT_BITS-1:DIGIT_BITS];
        K_LEAD: m_nxt     = prod[DIGIT_BITS-1:0];
        K_FIN: begin
          borrow_nxt = diff[DIGIT_BITS];
          if (stp_r.keep) begin
            u_sr_nxt = u_sr_r >> DIGIT_BITS;
            d_sr_nxt = d_sr_r >> DIGIT_BITS;
            u_sr_nxt[DW-1 -: DIGIT_BITS] = rd_r;
            d_sr_nxt[DW-1 -: DIGIT_BITS] = diff[DIGIT_BITS-1:0];
          end
        end
        K_SHIFT: begin
          u_sr_nxt = u_sr_r >> DIGIT_BITS;
          d_sr_nxt = d_sr_r >> DIGIT_BITS;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      t_mem_r[addr_r] <= sum[DIGIT_BITS-1:0];
    end
    rd_r <= t_mem_r[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stp_r <= '0;
    end else begin
      stp_r <= step;
    end
  end

  always_ff @(posedge clk) begin
    addr_r   <= addr;
    carry_r  <= carry_nxt;
    m_r      <= m_nxt;
    borrow_r <= borrow_nxt;
    u_sr_r   <= u_sr_nxt;
    d_sr_r   <= d_sr_nxt;
  end

  // U when U < n, else U - n
  assign result = borrow_r ? u_sr_r : d_sr_r;

endmodule

@@ rtl/montgomery_multiply_sos.sv @@
// Montgomery multiplier top level: channels, register port, output register.
// Depends on mmsos_pkg, mmsos_if, mmsos_cfg, mmsos_seq and mmsos_dpath.
//
// Computes a*b*R^-1 mod n on 4-bit digits with R = 16^s, s the digit_count
// register clamped to 1..DIGITS; operands and modulus are cut to their low s
// digits. Separated operand scanning: the full 2s-digit product goes into a
// (2*DIGITS+1)-digit memory, s reduction passes follow (n0' = -n^-1 mod 16 is
// derived from the modulus' low digit), then one conditional subtraction.
// Everything runs through a single 4x4 multiply-accumulate and one memory
// read plus one write per cycle, one item at a time. An even modulus skips
// the arithmetic: the sequencer goes straight to its done state and the
// item returns product 0 with bad_modulus set through the output register.
// The result sits in an output register, so the next item can be accepted
// while it waits. Write registers only while no item is in flight.
module montgomery_multiply_sos #(
  parameter int unsigned DIGITS = mmsos_pkg::DIGITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  mmsos_in_if.sink                          in_ch,
  mmsos_out_if.source                       out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mmsos_pkg::PADDR_W-1:0]     paddr,
  input  logic [mmsos_pkg::FIELD_W-1:0]     pwdata,
  output logic [mmsos_pkg::FIELD_W-1:0]     prdata,
  output logic                              pready
);
  import mmsos_pkg::*;

  localparam int unsigned DW = DIGITS * DIGIT_BITS;
  localparam int unsigned AW = $clog2(2*DIGITS + 1);

  logic [FIELD_W-1:0] modulus;
  logic [DC_W-1:0]    digit_count;
  step_t              step;
  logic [AW-1:0]      addr;
  seq_stat_t          stat;
  logic [DW-1:0]      result;
  logic               start, take;

  logic               out_vld_r, out_vld_nxt;
  logic [FIELD_W-1:0] product_r;
  logic               bad_r;

  mmsos_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .modulus     (modulus),
    .digit_count (digit_count)
  );

  mmsos_seq #(.DIGITS(DIGITS)) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .take        (take),
    .operand_a   (in_ch.operand_a),
    .operand_b   (in_ch.operand_b),
    .modulus     (modulus),
    .digit_count (digit_count),
    .step        (step),
    .addr        (addr),
    .stat        (stat)
  );

  mmsos_dpath #(.DIGITS(DIGITS)) u_dpath (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .addr   (addr),
    .result (result)
  );

  // one item in the core at a time
  assign in_ch.ready = stat.idle;
  assign start       = in_ch.valid && stat.idle;

  // hand the finished result to the output register when it is free
  assign take = stat.done && (!out_vld_r || out_ch.ready);

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (take) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      product_r <= stat.bad ? '0 : FIELD_W'(result);
      bad_r     <= stat.bad;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.product     = product_r;
  assign out_ch.bad_modulus = bad_r;

endmodule

@@ rtl/mmsos_chk.sv @@
// Port-level checker for the Montgomery multiplier, bound to the top level.
// Depends on mmsos_pkg and montgomery_multiply_sos.
module mmsos_chk #(
  parameter int unsigned DIGITS = mmsos_pkg::DIGITS_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [mmsos_pkg::FIELD_W-1:0] product,
  input logic                          bad_modulus
);
  import mmsos_pkg::*;

  // an even modulus always reports a zero product
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && bad_modulus |-> product == '0)
    else $error("bad_modulus item with nonzero product");

  // digits above DIGITS never show up in the result
  a_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (product >> (DIGIT_BITS * DIGITS)) == '0)
    else $error("product has digits beyond DIGITS");

  // core takes one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted back to back");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(product) && $stable(bad_modulus))
    else $error("stalled result changed");

endmodule

bind montgomery_multiply_sos mmsos_chk #(.DIGITS(DIGITS)) u_mmsos_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .product     (out_ch.product),
  .bad_modulus (out_ch.bad_modulus)
);
